@@ src/tnps_pkg.sv @@
// Shared types and constants for the thresholded nearest-point search core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tnps_pkg;

  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned CoordBitsDef = 16;

  localparam int unsigned PtW    = 16;  // width of one coordinate port
  localparam int unsigned RadW   = 34;  // squared radius register
  localparam int unsigned IdxOutW = 9;  // result index port

  // item command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // write the input point into the store
    logic capture;  // latch the query point, restart the scan
    logic issue;    // read one stored point into the distance pipe
    logic publish;  // move the search result into the output register
  } tnps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;      // store holds no points
    logic scan_last;  // scan address is the last stored entry
    logic pipe_busy;  // distance pipe still holds entries
    logic out_free;   // output register can take a result this cycle
  } tnps_sts_t;

endpackage

`default_nettype wire

@@ src/tnps_ctrl.sv @@
// Controller of the nearest-point search: accepts items, sequences the scan.
// Depends on tnps_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tnps_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               cmd_i,
  input  wire tnps_pkg::tnps_sts_t sts_i,
  output tnps_pkg::tnps_cmd_t     cmd_o
);
  import tnps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   in_xfer;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd_i == CMD_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = !sts_i.empty;
        if (sts_i.empty || sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/tnps_dp.sv @@
// Datapath of the nearest-point search: point store, distance pipe, best
// tracker, radius register and output register. Depends on tnps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tnps_dp #(
  parameter int unsigned MAX_POINTS = tnps_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = tnps_pkg::CoordBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [tnps_pkg::RadW-1:0]     cfg_wdata_i,
  input  wire logic                                 first_i,
  input  wire logic signed [tnps_pkg::PtW-1:0]      px_i,
  input  wire logic signed [tnps_pkg::PtW-1:0]      py_i,
  input  wire logic signed [tnps_pkg::PtW-1:0]      pz_i,
  input  wire tnps_pkg::tnps_cmd_t                  cmd_i,
  output tnps_pkg::tnps_sts_t                       sts_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic             [tnps_pkg::IdxOutW-1:0]  nearest_index_o,
  output logic                                      found_o
);
  import tnps_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned DFW   = COORD_BITS + 1;
  localparam int unsigned SQW   = 2 * DFW;
  localparam int unsigned SUMW  = SQW + 2;
  localparam int unsigned CMPW  = (SUMW > RadW) ? SUMW : RadW;
  localparam int unsigned ENTW  = 3 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // configuration
  logic [RadW-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // point store and fill count
  logic [ENTW-1:0]  mem [MAX_POINTS];
  logic [CNT_W-1:0] count_q;
  logic             full;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  coord_t           in_x, in_y, in_z;

  assign in_x   = COORD_BITS'(px_i);
  assign in_y   = COORD_BITS'(py_i);
  assign in_z   = COORD_BITS'(pz_i);
  assign full   = (count_q == CNT_W'(MAX_POINTS));
  assign mem_we = cmd_i.load && (first_i || !full);
  assign waddr  = first_i ? '0 : count_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (mem_we) begin
      count_q <= first_i ? CNT_W'(1) : count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= {in_z, in_y, in_x};
    end
  end

  // query point and scan address
  coord_t        qx_q, qy_q, qz_q;
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      qx_q <= in_x;
      qy_q <= in_y;
      qz_q <= in_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.capture) begin
      addr_q <= '0;
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // stage 1: registered store read
  logic [ENTW-1:0] rdata_q;
  logic [AW-1:0]   idx1_q, idx2_q, idx3_q;
  logic            v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem[addr_q];
    end
  end

  // stage 2: per-axis squared differences
  logic signed [DFW-1:0] dx, dy, dz;
  logic signed [SQW-1:0] px2, py2, pz2;
  logic        [SQW-1:0] sqx_q, sqy_q, sqz_q;

  always_comb begin
    dx  = DFW'(qx_q) - DFW'(coord_t'(rdata_q[COORD_BITS-1:0]));
    dy  = DFW'(qy_q) - DFW'(coord_t'(rdata_q[2*COORD_BITS-1:COORD_BITS]));
    dz  = DFW'(qz_q) - DFW'(coord_t'(rdata_q[ENTW-1:2*COORD_BITS]));
    px2 = dx * dx;
    py2 = dy * dy;
    pz2 = dz * dz;
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= $unsigned(px2);
    sqy_q <= $unsigned(py2);
    sqz_q <= $unsigned(pz2);
  end

  // stage 3: distance sum
  logic [SUMW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    sum_q  <= SUMW'(sqx_q) + SUMW'(sqy_q) + SUMW'(sqz_q);
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 4: best tracker; strict less keeps the lowest index on ties
  logic [SUMW-1:0] best_q;
  logic [AW-1:0]   best_idx_q;
  logic            hit_q;
  logic            in_radius;
  logic            better;

  assign in_radius = (CMPW'(sum_q) <= CMPW'(radius_q));
  assign better    = v3_q && in_radius && (!hit_q || (sum_q < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_q <= 1'b0;
    end else if (better) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_q     <= sum_q;
      best_idx_q <= idx3_q;
    end
  end

  // output register
  logic               out_valid_q;
  logic [IdxOutW-1:0] out_idx_q;
  logic               out_found_q;
  logic [CNT_W-1:0]   res_idx;

  assign res_idx = hit_q ? CNT_W'(best_idx_q) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_idx_q   <= IdxOutW'(res_idx);
      out_found_q <= hit_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q;
  assign found_o         = out_found_q;

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.scan_last = (CNT_W'(addr_q) == (count_q - CNT_W'(1)));
  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

@@ src/thresholded_nearest_point_search_core.sv @@
// Thresholded nearest-point search core: top level joining controller and
// datapath. Depends on tnps_pkg, tnps_ctrl and tnps_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries cmd, first and px/py/pz.
//   A load item (cmd 0) writes one reference point unless the store is
//   full and first is clear; first set restarts the store at index 0.
//   Loads are accepted back to back and produce no result. A query item
//   (cmd 1) scans all N stored points through one distance unit fed by
//   the single store read port, one point per cycle. Its result transfers
//   on the output channel (out_valid_o / out_stall_i); the input channel
//   stalls until the result is in the output register.
//   Loads are taken while a result waits; a second query waits in its
//   result step while the receiver stalls the first result.
//   cfg_we_i writes the squared radius; write it only while idle.
//   Reset empties the store and zeroes the radius; the points themselves
//   are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module thresholded_nearest_point_search_core #(
  parameter int unsigned MAX_POINTS = tnps_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = tnps_pkg::CoordBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [tnps_pkg::RadW-1:0]     cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 cmd_i,
  input  wire logic                                 first_i,
  input  wire logic signed [tnps_pkg::PtW-1:0]      px_i,
  input  wire logic signed [tnps_pkg::PtW-1:0]      py_i,
  input  wire logic signed [tnps_pkg::PtW-1:0]      pz_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic             [tnps_pkg::IdxOutW-1:0]  nearest_index_o,
  output logic                                      found_o
);
  import tnps_pkg::*;

  tnps_cmd_t cmd;
  tnps_sts_t sts;

  tnps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tnps_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .first_i         (first_i),
    .px_i            (px_i),
    .py_i            (py_i),
    .pz_i            (pz_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .nearest_index_o (nearest_index_o),
    .found_o         (found_o)
  );

endmodule

`default_nettype wire

@@ src/tnps_chk.sv @@
// Port-level checks for the thresholded nearest-point search core, and the
// bind that attaches them to the top level. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tnps_chk #(
  parameter int unsigned MAX_POINTS = 256
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        cmd_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [8:0]  nearest_index_o,
  input wire logic        found_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(nearest_index_o) && $stable(found_o))
    else $error("result payload changed while stalled");

  // loads never hold off the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !cmd_i |=> !in_stall_o)
    else $error("input stalled after a load transfer");

  // a query occupies the block while it scans
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i |=> in_stall_o)
    else $error("input taken during a query scan");

  // a hit names a stored entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && (MAX_POINTS <= 256) |-> (nearest_index_o < MAX_POINTS))
    else $error("hit index beyond the store");

endmodule

bind thresholded_nearest_point_search_core tnps_chk #(
  .MAX_POINTS (MAX_POINTS)
) u_tnps_chk (.*);

`default_nettype wire
